// ===== hw/rtl/mse_pkg.sv =====
// shared types and constants for the merge sort engine
// no dependencies
package mse_pkg;

    localparam int DEPTH_DEFAULT = 64;
    localparam int VALUE_W       = 32;

    typedef enum logic [4:0] {
        T_LOAD      = 5'b00001,
        T_SORT      = 5'b00010,
        T_EMIT_RD   = 5'b00100,
        T_EMIT_LD   = 5'b01000,
        T_EMIT_WAIT = 5'b10000
    } t_top_state;

    typedef enum logic [3:0] {
        M_IDLE  = 4'b0001,
        M_RUN   = 4'b0010,
        M_FETCH = 4'b0100,
        M_CMP   = 4'b1000
    } t_merge_state;

    typedef struct packed {
        logic done;
        logic src;
    } t_merge_status;

endpackage

// ===== hw/rtl/mse_ram.sv =====
// generic simple ram: one write port, two registered read ports
// no dependencies
module mse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

// ===== hw/rtl/mse_merge.sv =====
// bottom-up merge sequencer with one shared signed comparator
// depends on mse_pkg; drives the ping-pong stores held in the top level
module mse_merge #(
    parameter int DEPTH = mse_pkg::DEPTH_DEFAULT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [$clog2(DEPTH+1)-1:0]    i_count,
    input  logic [mse_pkg::VALUE_W-1:0]   i_rdata_l,
    input  logic [mse_pkg::VALUE_W-1:0]   i_rdata_r,
    output logic [$clog2(DEPTH)-1:0]      o_raddr_l,
    output logic [$clog2(DEPTH)-1:0]      o_raddr_r,
    output logic                          o_we,
    output logic [$clog2(DEPTH)-1:0]      o_waddr,
    output logic [mse_pkg::VALUE_W-1:0]   o_wdata,
    output mse_pkg::t_merge_status        o_status
);

    localparam int AW = $clog2(DEPTH);
    localparam int IW = $clog2(DEPTH + 1);
    localparam int SW = IW + 2;

    mse_pkg::t_merge_state r_state, n_state;
    logic [IW-1:0] r_cnt, n_cnt;
    logic [IW-1:0] r_w, n_w;
    logic [IW-1:0] r_lo, n_lo;
    logic [IW-1:0] r_mid, n_mid;
    logic [IW-1:0] r_hi, n_hi;
    logic [IW-1:0] r_l, n_l;
    logic [IW-1:0] r_r, n_r;
    logic [IW-1:0] r_k, n_k;
    logic          r_src, n_src;
    logic          r_done, n_done;

    logic [SW-1:0] sum_mid;
    logic [SW-1:0] sum_hi;
    logic [SW-1:0] w_dbl;
    logic          l_ok;
    logic          r_ok;
    logic          take_l;

    assign sum_mid = SW'(r_lo) + SW'(r_w);
    assign sum_hi  = SW'(r_lo) + (SW'(r_w) << 1);
    assign w_dbl   = SW'(r_w) << 1;
    assign l_ok    = (r_l < r_mid);
    assign r_ok    = (r_r < r_hi);
    assign take_l  = l_ok && (!r_ok || ($signed(i_rdata_l) < $signed(i_rdata_r)));

    assign o_raddr_l = l_ok ? r_l[AW-1:0] : '0;
    assign o_raddr_r = r_ok ? r_r[AW-1:0] : '0;
    assign o_we      = (r_state == mse_pkg::M_CMP);
    assign o_waddr   = r_k[AW-1:0];
    assign o_wdata   = take_l ? i_rdata_l : i_rdata_r;

    assign o_status.done = r_done;
    assign o_status.src  = r_src;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_w     = r_w;
        n_lo    = r_lo;
        n_mid   = r_mid;
        n_hi    = r_hi;
        n_l     = r_l;
        n_r     = r_r;
        n_k     = r_k;
        n_src   = r_src;
        n_done  = 1'b0;
        case (r_state)
            mse_pkg::M_IDLE: begin
                if (i_start) begin
                    n_cnt = i_count;
                    n_w   = IW'(1);
                    n_lo  = '0;
                    n_src = 1'b0;
                    if (i_count <= IW'(1)) begin
                        n_done = 1'b1;
                    end else begin
                        n_state = mse_pkg::M_RUN;
                    end
                end
            end
            mse_pkg::M_RUN: begin
                n_mid   = (sum_mid > SW'(r_cnt)) ? r_cnt : sum_mid[IW-1:0];
                n_hi    = (sum_hi > SW'(r_cnt)) ? r_cnt : sum_hi[IW-1:0];
                n_l     = r_lo;
                n_r     = n_mid;
                n_k     = r_lo;
                n_state = mse_pkg::M_FETCH;
            end
            mse_pkg::M_FETCH: begin
                n_state = mse_pkg::M_CMP;
            end
            mse_pkg::M_CMP: begin
                if (take_l) begin
                    n_l = r_l + IW'(1);
                end else begin
                    n_r = r_r + IW'(1);
                end
                n_k = r_k + IW'(1);
                if (r_k + IW'(1) == r_hi) begin
                    if (r_hi == r_cnt) begin
                        n_src = ~r_src;
                        if (w_dbl >= SW'(r_cnt)) begin
                            n_done  = 1'b1;
                            n_state = mse_pkg::M_IDLE;
                        end else begin
                            n_w     = w_dbl[IW-1:0];
                            n_lo    = '0;
                            n_state = mse_pkg::M_RUN;
                        end
                    end else begin
                        n_lo    = r_hi;
                        n_state = mse_pkg::M_RUN;
                    end
                end else begin
                    n_state = mse_pkg::M_FETCH;
                end
            end
            default: begin
                n_state = mse_pkg::M_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mse_pkg::M_IDLE;
            r_done  <= 1'b0;
            r_src   <= 1'b0;
            r_mid   <= '0;
            r_hi    <= '0;
            r_l     <= '0;
            r_r     <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_src   <= n_src;
            r_mid   <= n_mid;
            r_hi    <= n_hi;
            r_l     <= n_l;
            r_r     <= n_r;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_w   <= n_w;
        r_lo  <= n_lo;
        r_k   <= n_k;
    end

endmodule

// ===== hw/rtl/merge_sort_engine_unit.sv =====
// merge sort engine top level: load, sort and emit control around two stores
// depends on mse_pkg, mse_ram and mse_merge
//
// input channel: i_valid/o_ready carry one signed word (i_value) per handshake;
// i_is_last closes the set and starts the sort. the block is ready only while
// loading, one word per cycle. up to DEPTH words are kept; later words of the
// same set, the last one included, are dropped and the overflow flag is set.
// sorting runs bottom-up merge passes over two ping-pong stores with a single
// comparator: each pass fetches and compares every word in turn, with a setup
// step per merged run pair, ceil(log2(n)) passes for n words.
// output channel: o_valid/i_ready carry the sorted words in ascending order,
// o_last_out on the final one and o_overflow on all of them. each word goes
// through a load and a wait state as set by the store's registered read; a
// stalled receiver holds the output register and the emit sequence waits. after
// the final word is taken the block returns to loading with the count and
// overflow cleared.
// synchronous active-low reset returns the block to loading an empty set;
// store contents are not cleared.
module merge_sort_engine_unit #(
    parameter int DEPTH = mse_pkg::DEPTH_DEFAULT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [mse_pkg::VALUE_W-1:0] i_value,
    input  logic                        i_is_last,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [mse_pkg::VALUE_W-1:0] o_sorted_value,
    output logic                        o_last_out,
    output logic                        o_overflow
);

    localparam int AW = $clog2(DEPTH);
    localparam int IW = $clog2(DEPTH + 1);

    mse_pkg::t_top_state r_state, n_state;
    logic [IW-1:0] r_count, n_count;
    logic          r_ovf, n_ovf;
    logic [IW-1:0] r_eidx, n_eidx;
    logic          r_valid, n_valid;
    logic [mse_pkg::VALUE_W-1:0] r_data, n_data;
    logic          r_last, n_last;
    logic          r_oflag, n_oflag;

    logic          in_acc;
    logic          out_acc;
    logic          room;
    logic [IW-1:0] cnt_after;
    logic          load_we;
    logic          emitting;
    logic [AW-1:0] emit_addr;

    mse_pkg::t_merge_status m_status;
    logic [AW-1:0] m_raddr_l, m_raddr_r;
    logic          m_we;
    logic [AW-1:0] m_waddr;
    logic [mse_pkg::VALUE_W-1:0] m_wdata;

    logic [AW-1:0] raddr_a, raddr_b;
    logic [mse_pkg::VALUE_W-1:0] s0_a, s0_b, s1_a, s1_b;
    logic [mse_pkg::VALUE_W-1:0] src_a, src_b;
    logic          s0_we, s1_we;
    logic [AW-1:0] s0_waddr;
    logic [mse_pkg::VALUE_W-1:0] s0_wdata;

    assign o_ready   = (r_state == mse_pkg::T_LOAD);
    assign in_acc    = i_valid && o_ready;
    assign out_acc   = r_valid && i_ready;
    assign room      = (r_count < IW'(DEPTH));
    assign cnt_after = room ? (r_count + IW'(1)) : r_count;
    assign load_we   = in_acc && room;

    assign emitting  = r_state inside {mse_pkg::T_EMIT_RD, mse_pkg::T_EMIT_LD,
                                       mse_pkg::T_EMIT_WAIT};
    assign emit_addr = (r_eidx < r_count) ? r_eidx[AW-1:0] : '0;
    assign raddr_a   = emitting ? emit_addr : m_raddr_l;
    assign raddr_b   = m_raddr_r;

    assign src_a     = m_status.src ? s1_a : s0_a;
    assign src_b     = m_status.src ? s1_b : s0_b;

    assign s0_we     = load_we || (m_we && m_status.src);
    assign s0_waddr  = load_we ? r_count[AW-1:0] : m_waddr;
    assign s0_wdata  = load_we ? i_value : m_wdata;
    assign s1_we     = m_we && !m_status.src;

    mse_ram #(
        .WIDTH (mse_pkg::VALUE_W),
        .DEPTH (DEPTH)
    ) u_elem_store (
        .i_clk     (i_clk),
        .i_we      (s0_we),
        .i_waddr   (s0_waddr),
        .i_wdata   (s0_wdata),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (s0_a),
        .o_rdata_b (s0_b)
    );

    mse_ram #(
        .WIDTH (mse_pkg::VALUE_W),
        .DEPTH (DEPTH)
    ) u_merge_store (
        .i_clk     (i_clk),
        .i_we      (s1_we),
        .i_waddr   (m_waddr),
        .i_wdata   (m_wdata),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (s1_a),
        .o_rdata_b (s1_b)
    );

    mse_merge #(
        .DEPTH (DEPTH)
    ) u_merge (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (in_acc && i_is_last),
        .i_count   (cnt_after),
        .i_rdata_l (src_a),
        .i_rdata_r (src_b),
        .o_raddr_l (m_raddr_l),
        .o_raddr_r (m_raddr_r),
        .o_we      (m_we),
        .o_waddr   (m_waddr),
        .o_wdata   (m_wdata),
        .o_status  (m_status)
    );

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_ovf   = r_ovf;
        n_eidx  = r_eidx;
        n_valid = r_valid;
        n_data  = r_data;
        n_last  = r_last;
        n_oflag = r_oflag;
        case (r_state)
            mse_pkg::T_LOAD: begin
                if (in_acc) begin
                    n_count = cnt_after;
                    if (!room) begin
                        n_ovf = 1'b1;
                    end
                    if (i_is_last) begin
                        n_state = mse_pkg::T_SORT;
                    end
                end
            end
            mse_pkg::T_SORT: begin
                n_eidx = '0;
                if (m_status.done) begin
                    n_state = mse_pkg::T_EMIT_RD;
                end
            end
            mse_pkg::T_EMIT_RD: begin
                n_state = mse_pkg::T_EMIT_LD;
            end
            mse_pkg::T_EMIT_LD: begin
                n_valid = 1'b1;
                n_data  = src_a;
                n_last  = (r_eidx + IW'(1) == r_count);
                n_oflag = r_ovf;
                n_eidx  = r_eidx + IW'(1);
                n_state = mse_pkg::T_EMIT_WAIT;
            end
            mse_pkg::T_EMIT_WAIT: begin
                if (out_acc) begin
                    n_valid = 1'b0;
                    if (r_last) begin
                        n_count = '0;
                        n_ovf   = 1'b0;
                        n_state = mse_pkg::T_LOAD;
                    end else begin
                        n_state = mse_pkg::T_EMIT_LD;
                    end
                end
            end
            default: begin
                n_state = mse_pkg::T_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mse_pkg::T_LOAD;
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_eidx  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovf   <= n_ovf;
            r_eidx  <= n_eidx;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data  <= n_data;
        r_last  <= n_last;
        r_oflag <= n_oflag;
    end

    assign o_valid        = r_valid;
    assign o_sorted_value = r_data;
    assign o_last_out     = r_last;
    assign o_overflow     = r_oflag;

endmodule
